[rtl/core/vfdfs_pkg.sv]
// ============================================================================
// Frame store grid scanner package
// Shared types and constants for the frame store and its grid scanner.
// ============================================================================
`default_nettype none

package vfdfs_pkg;

    // Default panel geometry.
    localparam int DEF_COLUMNS = 128;
    localparam int DEF_ROWS    = 32;

    // One grid is refreshed by 64 serial bits: two columns of 32 rows.
    localparam int GRID_W = 6;
    localparam int BIT_W  = 6;

    // Command codes carried on the kind field.
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_SCAN  = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_PIXEL = 2'd2,
        ST_SCAN  = 2'd3
    } t_state;

    // Read request status from the scanner to the frame store controller.
    typedef struct packed {
        logic active;      // scanner owns the read port this cycle
        logic last_issue;  // this is the read for the final bit of the grid
    } t_scan_req;

endpackage

`default_nettype wire

[rtl/core/vfdfs_scanner.sv]
// ============================================================================
// Grid scanner
// Walks the 64 serial bits of one grid, issues one frame store read per bit
// and formats the registered read data into output words.
// ============================================================================
`default_nettype none

module vfdfs_scanner
    import vfdfs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [7:0]       i_rd_data,
    output t_scan_req             o_req,
    output logic [COL_W-1:0]      o_rd_col,
    output logic [1:0]            o_rd_byte,
    output logic                  o_valid,
    output logic                  o_serial_bit,
    output logic [GRID_W-1:0]     o_grid_index,
    output logic                  o_grid_start,
    output logic                  o_odd_bank,
    output logic                  o_last
);

    localparam logic [COL_W-1:0] EVEN_COL0 = COL_W'(2 % COLUMNS);
    localparam logic [COL_W-1:0] ODD_COL0  = COL_W'(1 % COLUMNS);

    logic              r_active, n_active;
    logic [BIT_W-1:0]  r_k, n_k;
    logic [GRID_W-1:0] r_grid, n_grid;
    logic [COL_W-1:0]  r_even_col, n_even_col;
    logic [COL_W-1:0]  r_odd_col, n_odd_col;

    logic              r_s1_valid;
    logic [2:0]        r_s1_bit;
    logic              r_s1_ok;
    logic              r_s1_last;
    logic [GRID_W-1:0] r_s1_grid;

    logic              last_issue;
    logic              row_ok;
    logic [COL_W:0]    even_sum;
    logic [COL_W:0]    odd_sum;

    assign last_issue = r_active && (r_k == '1);
    // Row of the current bit is k/2; rows past the panel shift out as zero.
    assign row_ok     = ({2'b00, r_k[BIT_W-1:1]} < 7'(ROWS));

    assign o_req.active     = r_active;
    assign o_req.last_issue = last_issue;
    assign o_rd_col         = r_k[0] ? r_odd_col : r_even_col;
    assign o_rd_byte        = r_k[BIT_W-1:BIT_W-2];

    // Both columns step by two per grid; a single subtract keeps them in range.
    always_comb begin
        even_sum = {1'b0, r_even_col} + (COL_W+1)'(2);
        odd_sum  = {1'b0, r_odd_col} + (COL_W+1)'(2);
        if (even_sum >= (COL_W+1)'(COLUMNS)) begin
            even_sum = even_sum - (COL_W+1)'(COLUMNS);
        end
        if (odd_sum >= (COL_W+1)'(COLUMNS)) begin
            odd_sum = odd_sum - (COL_W+1)'(COLUMNS);
        end
    end

    always_comb begin
        n_active   = r_active;
        n_k        = r_active ? r_k + BIT_W'(1) : '0;
        n_grid     = r_grid;
        n_even_col = r_even_col;
        n_odd_col  = r_odd_col;
        if (i_go) begin
            n_active = 1'b1;
        end else if (last_issue) begin
            n_active = 1'b0;
        end
        if (last_issue) begin
            n_grid = r_grid + GRID_W'(1);
            if (r_grid == '1) begin
                n_even_col = EVEN_COL0;
                n_odd_col  = ODD_COL0;
            end else begin
                n_even_col = even_sum[COL_W-1:0];
                n_odd_col  = odd_sum[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_k        <= '0;
            r_grid     <= '0;
            r_even_col <= EVEN_COL0;
            r_odd_col  <= ODD_COL0;
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_k        <= n_k;
            r_grid     <= n_grid;
            r_even_col <= n_even_col;
            r_odd_col  <= n_odd_col;
            r_s1_valid <= r_active;
            o_valid    <= r_s1_valid;
        end
    end

    // Stage one travels alongside the memory read; stage two is the output word.
    always_ff @(posedge i_clk) begin
        r_s1_bit     <= r_k[3:1];
        r_s1_ok      <= row_ok;
        r_s1_last    <= (r_k == '1);
        r_s1_grid    <= r_grid;
        o_serial_bit <= i_rd_data[r_s1_bit] & r_s1_ok;
        o_grid_index <= r_s1_grid;
        o_grid_start <= (r_s1_grid[GRID_W-1:1] == '0);
        o_odd_bank   <= r_s1_grid[0];
        o_last       <= r_s1_last;
    end

endmodule

`default_nettype wire

[rtl/core/vfd_frame_store_grid_scanner.sv]
// ============================================================================
// Frame store grid scanner
// One-bit frame store for a vacuum fluorescent panel with pixel and byte
// writes, and a grid scanner that shifts out 64 anode bits per grid.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ---------------------------------
// command   in         start high, busy low   i_kind, i_column, i_pixel_row,
//                                             i_pixel_on, i_byte_index,
//                                             i_byte_value
// result    out        o_valid, one cycle     o_serial_bit, o_grid_index,
//                                             o_grid_start, o_odd_bank, o_last
//
// After reset the block sweeps the frame store once to clear it, one byte per
// cycle, COLUMNS times the padded bytes per column (512 at the default size);
// busy stays high until the sweep ends. A byte write never raises busy. A
// pixel write is a read-modify-write on the single frame store memory and
// holds busy for one cycle. A scan word holds busy while the scanner issues
// one frame store read per serial bit; its 64 words pass the registered read
// data and the output register, one word per cycle. The receiver cannot
// stall, so a result word is on the ports for exactly one cycle.
//
`default_nettype none

module vfd_frame_store_grid_scanner
    import vfdfs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_kind,
    input  wire logic [7:0]        i_column,
    input  wire logic [7:0]        i_pixel_row,
    input  wire logic              i_pixel_on,
    input  wire logic [1:0]        i_byte_index,
    input  wire logic [7:0]        i_byte_value,
    output logic                   o_valid,
    output logic                   o_serial_bit,
    output logic [GRID_W-1:0]      o_grid_index,
    output logic                   o_grid_start,
    output logic                   o_odd_bank,
    output logic                   o_last
);

    // The store is addressed as {column, byte}, with the byte field padded to
    // a power of two so that no multiply is needed to form an address.
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int COL_BYTES = (ROWS + 7) / 8;
    localparam int BYTE_W    = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;
    localparam int ADDR_W    = COL_W + BYTE_W;
    localparam int DEPTH     = COLUMNS << BYTE_W;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_pix_addr;
    logic [2:0]        r_pix_bit;
    logic              r_pix_on;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;

    logic              accept;
    logic              pix_ok;
    logic              byte_ok;
    logic              scan_go;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] in_pix_addr;
    logic [ADDR_W-1:0] in_byte_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic [7:0]        pix_mask;

    t_scan_req         scan_req;
    logic [COL_W-1:0]  scan_col;
    logic [1:0]        scan_byte;

    // A command is taken only while the controller is idle.
    assign accept  = start && !busy;

    // Pixels off the panel and bytes beyond the column are dropped silently.
    assign pix_ok  = ({1'b0, i_column} < 9'(COLUMNS)) && ({1'b0, i_pixel_row} < 9'(ROWS));
    assign byte_ok = ({1'b0, i_column} < 9'(COLUMNS))
                     && ({2'b00, i_byte_index} < 4'(COL_BYTES));
    assign scan_go = accept && (i_kind == KIND_SCAN);

    assign in_pix_addr  = {i_column[COL_W-1:0], BYTE_W'(i_pixel_row[7:3])};
    assign in_byte_addr = {i_column[COL_W-1:0], BYTE_W'(i_byte_index)};
    assign scan_addr    = {scan_col, BYTE_W'(scan_byte)};
    assign pix_mask     = 8'(1) << r_pix_bit;

    // The scanner owns the read port during a scan; otherwise the port serves
    // the read half of a pixel write.
    assign rd_addr = scan_req.active ? scan_addr : in_pix_addr;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PIXEL: begin
                            if (pix_ok) begin
                                n_state = ST_PIXEL;
                            end
                        end
                        KIND_SCAN: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIXEL: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_req.last_issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Controller outputs: busy flag and the frame store write port.
    always_comb begin
        busy    = 1'b1;
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = 8'h00;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = 8'h00;
            end
            ST_IDLE: begin
                busy    = 1'b0;
                wr_en   = start && (i_kind == KIND_BYTE) && byte_ok;
                wr_addr = in_byte_addr;
                wr_data = i_byte_value;
            end
            ST_PIXEL: begin
                wr_en   = 1'b1;
                wr_addr = r_pix_addr;
                wr_data = r_pix_on ? (r_rd_data | pix_mask) : (r_rd_data & ~pix_mask);
            end
            ST_SCAN: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Pixel write context, held for the modify half of the read-modify-write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix_addr <= in_pix_addr;
            r_pix_bit  <= i_pixel_row[2:0];
            r_pix_on   <= i_pixel_on;
        end
    end

    // Frame store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    vfdfs_scanner #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_scanner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (scan_go),
        .i_rd_data    (r_rd_data),
        .o_req        (scan_req),
        .o_rd_col     (scan_col),
        .o_rd_byte    (scan_byte),
        .o_valid      (o_valid),
        .o_serial_bit (o_serial_bit),
        .o_grid_index (o_grid_index),
        .o_grid_start (o_grid_start),
        .o_odd_bank   (o_odd_bank),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

[test/vfd_frame_store_grid_scanner_tb.sv]
// ============================================================================
// Frame store grid scanner testbench
// Drives pixel, byte, scan and unused command words into the scanner, keeps
// its own copy of the frame store and the grid counter, and checks every
// serial bit word that comes out against the copy, field by field.
// ============================================================================
`timescale 1ns / 100ps

module vfd_frame_store_grid_scanner_tb
    import vfdfs_pkg::*;
();

    localparam int PANEL_COLUMNS = DEF_COLUMNS;
    localparam int PANEL_ROWS    = DEF_ROWS;
    localparam int COLUMN_BYTES  = (PANEL_ROWS + 7) / 8;
    localparam int GRID_BITS     = 64;

    // The kind field has one code that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_WORDS  = 130;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    // One expected serial bit word, as the result ports show it.
    typedef struct packed {
        logic              serial_bit;
        logic [GRID_W-1:0] grid_index;
        logic              grid_start;
        logic              odd_bank;
        logic              last;
    } t_anode_bit;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic       start        = 1'b0;
    logic [1:0] i_kind       = '0;
    logic [7:0] i_column     = '0;
    logic [7:0] i_pixel_row  = '0;
    logic       i_pixel_on   = 1'b0;
    logic [1:0] i_byte_index = '0;
    logic [7:0] i_byte_value = '0;

    logic              busy;
    logic              o_valid;
    logic              o_serial_bit;
    logic [GRID_W-1:0] o_grid_index;
    logic              o_grid_start;
    logic              o_odd_bank;
    logic              o_last;

    // Our own copy of the panel contents and of the next grid to refresh.
    // Both start out cleared, which is what the reset sweep leaves behind.
    bit [7:0]          frame_bytes [PANEL_COLUMNS][COLUMN_BYTES];
    bit [GRID_W-1:0]   next_grid;

    t_anode_bit  anode_bits_due[$];
    int unsigned mismatch_count = 0;

    vfd_frame_store_grid_scanner #(
        .COLUMNS (PANEL_COLUMNS),
        .ROWS    (PANEL_ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_column     (i_column),
        .i_pixel_row  (i_pixel_row),
        .i_pixel_on   (i_pixel_on),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .o_valid      (o_valid),
        .o_serial_bit (o_serial_bit),
        .o_grid_index (o_grid_index),
        .o_grid_start (o_grid_start),
        .o_odd_bank   (o_odd_bank),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Panel model. Applies one accepted command word to the copy of the frame
    // store and, for a scan, queues the 64 serial bit words it must produce.
    // Even bits come from column 2g+2 (wrapping past the last column), odd
    // bits from column 2g+1, and bit k shows row k/2.
    // ------------------------------------------------------------------------
    task automatic model_command(input logic [1:0] kind, input logic [7:0] column,
                                 input logic [7:0] row, input logic on,
                                 input logic [1:0] bidx, input logic [7:0] bval);
        t_anode_bit  word;
        int unsigned col;
        int unsigned pix_row;
        case (kind)
            KIND_PIXEL: begin
                // A pixel off the panel is dropped without a trace.
                if (column < PANEL_COLUMNS && row < PANEL_ROWS)
                    frame_bytes[column][row >> 3][row[2:0]] = on;
            end
            KIND_BYTE: begin
                if (column < PANEL_COLUMNS && bidx < COLUMN_BYTES)
                    frame_bytes[column][bidx] = bval;
            end
            KIND_SCAN: begin
                for (int k = 0; k < GRID_BITS; k++) begin
                    if (k % 2 == 1)
                        col = (2 * next_grid + 1) % PANEL_COLUMNS;
                    else
                        col = (2 * next_grid + 2) % PANEL_COLUMNS;
                    pix_row = k / 2;
                    // Rows below the panel shift out as dark.
                    if (pix_row < PANEL_ROWS)
                        word.serial_bit = frame_bytes[col][pix_row / 8][pix_row % 8];
                    else
                        word.serial_bit = 1'b0;
                    word.grid_index = next_grid;
                    word.grid_start = (next_grid <= 1);
                    word.odd_bank   = next_grid[0];
                    word.last       = (k == GRID_BITS - 1);
                    anode_bits_due.push_back(word);
                end
                // The counter is six bits wide, so grid 63 rolls over to 0.
                next_grid = next_grid + 1'b1;
            end
            default: begin
                // The unused kind code changes nothing and gives no result.
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything here reads values from before the clock edge, so
    // the order of processes within the step does not matter. A result word
    // is checked before the command accepted on the same edge is modeled;
    // the block cannot answer a command on the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_anode_bit want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (anode_bits_due.size() == 0) begin
                    $error("serial bit word arrived with none expected");
                    mismatch_count++;
                end else begin
                    want = anode_bits_due.pop_front();
                    check_field("serial_bit", want.serial_bit, o_serial_bit);
                    check_field("grid_index", want.grid_index, o_grid_index);
                    check_field("grid_start", want.grid_start, o_grid_start);
                    check_field("odd_bank", want.odd_bank, o_odd_bank);
                    check_field("last", want.last, o_last);
                end
            end
            if (start && !busy)
                model_command(i_kind, i_column, i_pixel_row, i_pixel_on,
                              i_byte_index, i_byte_value);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. send_word is entered on a rising edge and returns on the
    // edge that accepts the word, with start still high, so that a following
    // word can go out back to back.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] kind, input logic [7:0] column,
                             input logic [7:0] row, input logic on,
                             input logic [1:0] bidx, input logic [7:0] bval);
        i_kind       <= kind;
        i_column     <= column;
        i_pixel_row  <= row;
        i_pixel_on   <= on;
        i_byte_index <= bidx;
        i_byte_value <= bval;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every queued serial bit has come out. A
    // bound keeps a lost word from hanging the run; what is left is a failure.
    // The word accepted on the calling edge is modeled by the monitor within
    // that same step, so one edge passes before the queue is looked at.
    task automatic wait_results_drained();
        int unsigned waited;
        start  <= 1'b0;
        @(posedge i_clk);
        waited = 1;
        while (anode_bits_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (anode_bits_due.size() != 0) begin
            $error("%0d expected serial bit words never arrived",
                   anode_bits_due.size());
            mismatch_count++;
            anode_bits_due.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Grids 0 and 1 on a blank panel: all dark, grid start pulse high, both
    // bank parities. The unused fields go to their extremes along the way.
    task automatic test_blank_after_reset();
        send_word(KIND_SCAN, 8'hFF, 8'hFF, 1'b1, 2'd3, 8'hFF);
        send_word(KIND_SCAN, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00);
    endtask

    // Pixel writes on the columns of grid 2 (even column 6, odd column 5),
    // at the panel corners, and just off the panel on each side.
    task automatic test_pixel_edges();
        send_word(KIND_PIXEL, 8'd6, 8'd0, 1'b1, 2'd0, 8'h00);
        send_word(KIND_PIXEL, 8'd6, 8'd31, 1'b1, 2'd0, 8'h00);
        send_word(KIND_PIXEL, 8'd5, 8'd31, 1'b1, 2'd3, 8'hFF);
        send_word(KIND_PIXEL, 8'd5, 8'd16, 1'b1, 2'd1, 8'h5A);
        send_word(KIND_PIXEL, 8'd5, 8'd16, 1'b0, 2'd2, 8'hA5);
        send_word(KIND_PIXEL, 8'd0, 8'd0, 1'b1, 2'd0, 8'h00);
        send_word(KIND_PIXEL, 8'd127, 8'd31, 1'b1, 2'd0, 8'h00);
        // Off the panel: one column too far, everything at maximum, one row
        // too far. None of these may touch the store.
        send_word(KIND_PIXEL, 8'd128, 8'd0, 1'b1, 2'd0, 8'h00);
        send_word(KIND_PIXEL, 8'd255, 8'd255, 1'b1, 2'd3, 8'hFF);
        send_word(KIND_PIXEL, 8'd6, 8'd32, 1'b1, 2'd0, 8'h00);
        send_word(KIND_SCAN, 8'd0, 8'd0, 1'b0, 2'd0, 8'h00);
    endtask

    // Byte writes on the columns of grid 3 (even column 8, odd column 7),
    // every byte index, an off-panel column, and a pixel clear that must
    // read back the byte written just before it.
    task automatic test_byte_writes();
        send_word(KIND_BYTE, 8'd8, 8'd0, 1'b0, 2'd3, 8'h80);
        send_word(KIND_BYTE, 8'd7, 8'd0, 1'b0, 2'd1, 8'hA5);
        send_word(KIND_BYTE, 8'd7, 8'd0, 1'b0, 2'd2, 8'h00);
        send_word(KIND_BYTE, 8'd200, 8'd0, 1'b0, 2'd0, 8'hFF);
        send_word(KIND_BYTE, 8'd8, 8'd0, 1'b0, 2'd0, 8'hFF);
        send_word(KIND_PIXEL, 8'd8, 8'd3, 1'b0, 2'd0, 8'h00);
        send_word(KIND_SCAN, 8'd0, 8'd0, 1'b0, 2'd0, 8'h00);
    endtask

    // The unused kind code with every field at its maximum; then the sender
    // waits for the panel to go quiet before anything else is sent.
    task automatic test_unused_kind();
        send_word(KIND_UNUSED, 8'hFF, 8'hFF, 1'b1, 2'd3, 8'hFF);
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Scans make up a good share, so the grid counter wraps
    // at least once and the whole panel is read back. Pixel rows and columns
    // stay mostly on the panel, with a share anywhere in their range. The
    // sender works in bursts with gaps of varying length, some long enough
    // to land the next word anywhere within a scan; a middle stretch has no
    // gaps at all, and once the sender waits for everything to drain.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned counted;
        int unsigned burst_left;
        int unsigned pick;
        bit          drained;
        bit          ignored;
        logic [1:0]  kind;
        logic [7:0]  column;
        logic [7:0]  row;
        counted    = 0;
        burst_left = 0;
        drained    = 1'b0;
        while (counted < RANDOM_WORDS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if (counted < 60 || counted > 90) begin
                    if ($urandom_range(0, 4) == 0)
                        pause_sender($urandom_range(1, 80));
                    else
                        pause_sender($urandom_range(0, 4));
                end
            end
            if (counted == 120 && !drained) begin
                wait_results_drained();
                drained = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (pick < 45)
                kind = KIND_SCAN;
            else if (pick < 68)
                kind = KIND_PIXEL;
            else if (pick < 95)
                kind = KIND_BYTE;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 9) == 0)
                column = 8'($urandom);
            else
                column = 8'($urandom_range(0, PANEL_COLUMNS - 1));
            if ($urandom_range(0, 4) == 0)
                row = 8'($urandom);
            else
                row = 8'($urandom_range(0, PANEL_ROWS - 1));

            send_word(kind, column, row, 1'($urandom), 2'($urandom), 8'($urandom));
            burst_left--;

            // Words the block just drops do not count toward the total.
            ignored = (kind == KIND_UNUSED)
                   || (kind == KIND_PIXEL
                       && (column >= PANEL_COLUMNS || row >= PANEL_ROWS))
                   || (kind == KIND_BYTE && column >= PANEL_COLUMNS);
            if (!ignored)
                counted++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence. After reset is released, the block clears its
    // frame store with busy high, which send_word simply waits out.
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blank_after_reset();
        test_pixel_edges();
        test_byte_writes();
        test_unused_kind();
        test_random_traffic();

        // Let the last grid shift out, then let the pipeline settle to show any stray word.
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // A watchdog that ends a hung run with an error; the slowest correct run,
    // including the reset sweep, finishes well inside it.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[vfd_frame_store_grid_scanner.f]
rtl/core/vfdfs_pkg.sv
rtl/core/vfdfs_scanner.sv
rtl/core/vfd_frame_store_grid_scanner.sv
test/vfd_frame_store_grid_scanner_tb.sv
